[hw/rtl/qts_pkg.sv]
`default_nettype none

package qts_pkg;

	// separator compare slots built into the datapath
	localparam int NUM_SEPARATORS = 4;
	// separator registers on the config port
	localparam int SEP_REGS = 4;
	// largest separator count that takes effect
	localparam int SEP_LIMIT = (NUM_SEPARATORS < SEP_REGS) ? NUM_SEPARATORS : SEP_REGS;

	localparam int CHAR_W = 8;
	localparam int COUNT_W = 3;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// special bytes
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

	// register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_SEP_COUNT = 3'd0,
		REG_SEP_A = 3'd1,
		REG_SEP_B = 3'd2,
		REG_SEP_C = 3'd3,
		REG_SEP_D = 3'd4
	} reg_idx_t;

	// reset values
	localparam logic [COUNT_W-1:0] SEP_COUNT_RST = 3'd4;
	localparam logic [CHAR_W-1:0] SEP_A_RST = 8'd32;
	localparam logic [CHAR_W-1:0] SEP_B_RST = 8'd9;
	localparam logic [CHAR_W-1:0] SEP_C_RST = 8'd10;
	localparam logic [CHAR_W-1:0] SEP_D_RST = 8'd13;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SEP_REGS-1:0][CHAR_W-1:0] sep;
	} sep_cfg_t;

	typedef struct packed {
		logic s1_valid;
		logic advance;
		logic in_tok;
	} core_status_t;

endpackage

`default_nettype wire

[hw/rtl/qts_char_if.sv]
`default_nettype none

interface qts_char_if;
	logic valid;
	logic ready;
	logic [qts_pkg::CHAR_W-1:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

[hw/rtl/qts_token_if.sv]
`default_nettype none

interface qts_token_if;
	logic valid;
	logic ready;
	logic [qts_pkg::CHAR_W-1:0] token_byte;
	logic token_end;

	modport source (output valid, output token_byte, output token_end, input ready);
	modport sink (input valid, input token_byte, input token_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/qts_regs.sv]
`default_nettype none

module qts_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [qts_pkg::ADDR_W-1:0] paddr,
	input wire logic [qts_pkg::DATA_W-1:0] pwdata,
	output logic [qts_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output qts_pkg::sep_cfg_t cfg
);

	qts_pkg::sep_cfg_t cfg_q;
	logic wr_en;
	qts_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = qts_pkg::reg_idx_t'(paddr[qts_pkg::ADDR_W-1:2]);
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count <= qts_pkg::SEP_COUNT_RST;
			cfg_q.sep[0] <= qts_pkg::SEP_A_RST;
			cfg_q.sep[1] <= qts_pkg::SEP_B_RST;
			cfg_q.sep[2] <= qts_pkg::SEP_C_RST;
			cfg_q.sep[3] <= qts_pkg::SEP_D_RST;
		end else if (wr_en) begin
			case (idx)
				qts_pkg::REG_SEP_COUNT: cfg_q.count <= pwdata[qts_pkg::COUNT_W-1:0];
				qts_pkg::REG_SEP_A: cfg_q.sep[0] <= pwdata[qts_pkg::CHAR_W-1:0];
				qts_pkg::REG_SEP_B: cfg_q.sep[1] <= pwdata[qts_pkg::CHAR_W-1:0];
				qts_pkg::REG_SEP_C: cfg_q.sep[2] <= pwdata[qts_pkg::CHAR_W-1:0];
				qts_pkg::REG_SEP_D: cfg_q.sep[3] <= pwdata[qts_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			qts_pkg::REG_SEP_COUNT: prdata = {{(qts_pkg::DATA_W-qts_pkg::COUNT_W){1'b0}},
				cfg_q.count};
			qts_pkg::REG_SEP_A: prdata = {{(qts_pkg::DATA_W-qts_pkg::CHAR_W){1'b0}}, cfg_q.sep[0]};
			qts_pkg::REG_SEP_B: prdata = {{(qts_pkg::DATA_W-qts_pkg::CHAR_W){1'b0}}, cfg_q.sep[1]};
			qts_pkg::REG_SEP_C: prdata = {{(qts_pkg::DATA_W-qts_pkg::CHAR_W){1'b0}}, cfg_q.sep[2]};
			qts_pkg::REG_SEP_D: prdata = {{(qts_pkg::DATA_W-qts_pkg::CHAR_W){1'b0}}, cfg_q.sep[3]};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/qts_core.sv]
`default_nettype none

module qts_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire qts_pkg::sep_cfg_t cfg,
	qts_char_if.sink chars,
	qts_token_if.source tokens,
	output qts_pkg::core_status_t status
);

	// input stage
	logic s1_valid_s1;
	logic [qts_pkg::CHAR_W-1:0] char_s1;

	// tokenizer state
	logic inside_q, esc_q, squote_q, dquote_q;

	// result register
	logic out_valid_q;
	logic [qts_pkg::CHAR_W-1:0] token_byte_q;
	logic token_end_q;

	logic advance;
	logic [qts_pkg::COUNT_W-1:0] eff_count;
	logic [qts_pkg::SEP_REGS-1:0] match;
	logic is_sep;

	logic inside_n, esc_n, squote_n, dquote_n;
	logic esc_c, squote_c, dquote_c;
	logic has_res, res_end;
	logic [qts_pkg::CHAR_W-1:0] res_byte;

	assign advance = s1_valid_s1 && (!out_valid_q || tokens.ready);
	assign chars.ready = !s1_valid_s1 || advance;

	assign tokens.valid = out_valid_q;
	assign tokens.token_byte = token_byte_q;
	assign tokens.token_end = token_end_q;

	assign status.s1_valid = s1_valid_s1;
	assign status.advance = advance;
	assign status.in_tok = inside_q;

	// separator match, count saturated to the number of compare slots
	assign eff_count = (cfg.count > qts_pkg::COUNT_W'(qts_pkg::SEP_LIMIT)) ?
		qts_pkg::COUNT_W'(qts_pkg::SEP_LIMIT) : cfg.count;

	always_comb begin
		for (int i = 0; i < qts_pkg::SEP_REGS; i++) begin
			match[i] = (qts_pkg::COUNT_W'(i) < eff_count) && (cfg.sep[i] == char_s1);
		end
	end

	assign is_sep = |match;

	// one tokenizer step
	always_comb begin
		inside_n = inside_q;
		esc_n = esc_q;
		squote_n = squote_q;
		dquote_n = dquote_q;
		has_res = 1'b0;
		res_end = 1'b0;
		res_byte = char_s1;
		// flags restart at a token start
		esc_c = inside_q ? esc_q : 1'b0;
		squote_c = inside_q ? squote_q : 1'b0;
		dquote_c = inside_q ? dquote_q : 1'b0;
		if (char_s1 == qts_pkg::CH_NUL) begin
			// end of string closes any open token and drops all flags
			inside_n = 1'b0;
			esc_n = 1'b0;
			squote_n = 1'b0;
			dquote_n = 1'b0;
			has_res = inside_q;
			res_end = 1'b1;
			res_byte = '0;
		end else if (!inside_q && is_sep) begin
			// leading separator skipped
			has_res = 1'b0;
		end else begin
			inside_n = 1'b1;
			esc_n = esc_c;
			squote_n = squote_c;
			dquote_n = dquote_c;
			has_res = 1'b1;
			if (esc_c) begin
				esc_n = 1'b0;
			end else if (char_s1 == qts_pkg::CH_BACKSLASH) begin
				esc_n = 1'b1;
			end else if (char_s1 == qts_pkg::CH_SQUOTE) begin
				squote_n = !squote_c;
			end else if (char_s1 == qts_pkg::CH_DQUOTE) begin
				dquote_n = !dquote_c;
			end else if (!squote_c && !dquote_c && is_sep) begin
				// unquoted separator ends the token
				inside_n = 1'b0;
				esc_n = 1'b0;
				squote_n = 1'b0;
				dquote_n = 1'b0;
				res_end = 1'b1;
				res_byte = '0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
		end
	end

	// state flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			esc_q <= 1'b0;
			squote_q <= 1'b0;
			dquote_q <= 1'b0;
		end else if (advance) begin
			inside_q <= inside_n;
			esc_q <= esc_n;
			squote_q <= squote_n;
			dquote_q <= dquote_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_res;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			token_byte_q <= res_byte;
			token_end_q <= res_end;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/quoted_token_splitter.sv]
// channel   dir   payload                     request taken when
// chars     sink  char_in[7:0]                valid && ready
// tokens    src   token_byte[7:0], token_end  valid && ready
// apb       sink  paddr[4:0], pwdata[31:0]    psel && penable && pwrite
//
// one byte per cycle while the tokens side is not stalled; each byte is held in the input
// register and, if it yields a result, then moves into the result register
// the input register frees up in the cycle its byte moves into the result register
// reset clears the flags and loads the default separators (space, tab, lf, cr)
// a stalled tokens side holds its result and backs up into chars.ready
`default_nettype none

module quoted_token_splitter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [qts_pkg::ADDR_W-1:0] paddr,
	input wire logic [qts_pkg::DATA_W-1:0] pwdata,
	output logic [qts_pkg::DATA_W-1:0] prdata,
	output logic pready,
	qts_char_if.sink chars,
	qts_token_if.source tokens
);

	qts_pkg::sep_cfg_t cfg;
	qts_pkg::core_status_t status;

	qts_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	qts_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.chars(chars),
		.tokens(tokens),
		.status(status)
	);

	// an end marker carries no byte
	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_end |-> tokens.token_byte == '0)
		else $error("end marker with nonzero byte");

	// a freshly loaded end marker means the token state has closed
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tokens.valid) && tokens.token_end |-> !status.in_tok)
		else $error("token still open after end marker");

	// a new result only comes from a byte moving out of the input register
	a_res_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tokens.valid) |-> $past(status.advance))
		else $error("result without a byte leaving the input stage");

	// a held input byte blocks new requests
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		status.s1_valid && !status.advance |-> !chars.ready)
		else $error("input accepted over a held byte");

endmodule

`default_nettype wire
